### rtl/core/rbcg_pkg.sv
// shared constants, types and widths for the rotated beam corner generator
package rbcg_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 24;
  localparam int DIM_BITS   = 20;

  localparam int PHASE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int U_W     = FRAC_W + 1;
  localparam int TRIG_W  = U_W + 1;

  localparam int SIN_STG = 6;
  localparam int GEO_STG = 3;
  localparam int NSTG    = SIN_STG + GEO_STG;

  localparam int NCOORD  = 8;
  localparam int PROD_W  = DIM_BITS + TRIG_W + 2;
  localparam int RND_SH  = 17;
  localparam int RND_W   = PROD_W - RND_SH;
  localparam int PLACE_W = ((COORD_BITS > RND_W) ? COORD_BITS : RND_W) + 1;

  localparam int OFS_OY  = COORD_BITS;
  localparam int OFS_ANG = 2 * COORD_BITS;
  localparam int OFS_LEN = OFS_ANG + ANGLE_BITS;
  localparam int OFS_WID = OFS_LEN + DIM_BITS;
  localparam int IN_W    = OFS_WID + DIM_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = NCOORD * COORD_BITS;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // horner coefficients of the sine polynomial, q24
  localparam int T1_W = 17;
  localparam int T2_W = 21;
  localparam int T3_W = 24;
  localparam int T4_W = 25;
  localparam logic [T1_W-1:0] SIN_C0 = T1_W'(2692);
  localparam logic [T1_W-1:0] SIN_C1 = T1_W'(78547);
  localparam logic [T2_W-1:0] SIN_C2 = T2_W'(1337020);
  localparam logic [T3_W-1:0] SIN_C3 = T3_W'(10837479);
  localparam logic [T4_W-1:0] SIN_C4 = T4_W'(26353589);
  localparam logic [U_W-1:0]  ONE_Q16 = U_W'(65536);

  localparam logic signed [PROD_W-1:0]  RND_HALF = PROD_W'(1) << (RND_SH - 1);
  localparam logic signed [PLACE_W-1:0] COORD_MAX = PLACE_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [PLACE_W-1:0] COORD_MIN = -COORD_MAX - PLACE_W'(1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic [DIM_BITS-1:0]          len;
    logic [DIM_BITS-1:0]          wid;
  } beam_t;

endpackage

### rtl/core/rbcg_sin.sv
// six stage pipelined fixed point sine of a quadrant and fraction
module rbcg_sin import rbcg_pkg::*; (
  input  logic                     clk_i,
  input  logic [SIN_STG-1:0]       en_i,
  input  logic [1:0]               quad_i,
  input  logic [FRAC_W-1:0]        frac_i,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic [U_W-1:0]    u_d;
  logic [2*U_W-1:0]  usq;
  logic [U_W-1:0]    u2_d;
  logic [2*U_W-1:0]  p1;
  logic [2*U_W-1:0]  p2;
  logic [T2_W+U_W-1:0] p3;
  logic [T3_W+U_W-1:0] p4;
  logic [T4_W+U_W-1:0] p5;
  logic [T1_W-1:0]   t1_d;
  logic [T2_W-1:0]   t2_d;
  logic [T3_W-1:0]   t3_d;
  logic [T4_W-1:0]   t4_d;
  logic [T4_W:0]     f;
  logic [T4_W:0]     f_rnd;
  logic [TRIG_W-1:0] mag_full;
  logic [U_W-1:0]    mag;
  logic signed [TRIG_W-1:0] sin_d;

  logic [U_W-1:0]  u_q  [0:4];
  logic [U_W-1:0]  u2_q [0:3];
  logic            neg_q[0:4];
  logic [T1_W-1:0] t1_q;
  logic [T2_W-1:0] t2_q;
  logic [T3_W-1:0] t3_q;
  logic [T4_W-1:0] t4_q;
  logic signed [TRIG_W-1:0] sin_q;

  always_comb begin
    u_d  = quad_i[0] ? (ONE_Q16 - {1'b0, frac_i}) : {1'b0, frac_i};
    usq  = u_d * u_d;
    u2_d = usq[U_W+15:16];
    p1   = SIN_C0 * u2_q[0];
    t1_d = SIN_C1 - T1_W'(p1 >> 16);
    p2   = t1_q * u2_q[1];
    t2_d = SIN_C2 - T2_W'(p2 >> 16);
    p3   = t2_q * u2_q[2];
    t3_d = SIN_C3 - T3_W'(p3 >> 16);
    p4   = t3_q * u2_q[3];
    t4_d = SIN_C4 - T4_W'(p4 >> 16);
    p5   = t4_q * u_q[4];
    f    = (T4_W+1)'(p5 >> 16);
    f_rnd    = f + (T4_W+1)'(128);
    mag_full = TRIG_W'(f_rnd >> 8);
    mag      = (mag_full > {1'b0, ONE_Q16}) ? ONE_Q16 : mag_full[U_W-1:0];
    sin_d    = neg_q[4] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q[0]   <= u_d;
      u2_q[0]  <= u2_d;
      neg_q[0] <= quad_i[1];
    end
    if (en_i[1]) begin
      t1_q     <= t1_d;
      u_q[1]   <= u_q[0];
      u2_q[1]  <= u2_q[0];
      neg_q[1] <= neg_q[0];
    end
    if (en_i[2]) begin
      t2_q     <= t2_d;
      u_q[2]   <= u_q[1];
      u2_q[2]  <= u2_q[1];
      neg_q[2] <= neg_q[1];
    end
    if (en_i[3]) begin
      t3_q     <= t3_d;
      u_q[3]   <= u_q[2];
      u2_q[3]  <= u2_q[2];
      neg_q[3] <= neg_q[2];
    end
    if (en_i[4]) begin
      t4_q     <= t4_d;
      u_q[4]   <= u_q[3];
      neg_q[4] <= neg_q[3];
    end
    if (en_i[5]) begin
      sin_q <= sin_d;
    end
  end

  assign sin_o = sin_q;

endmodule

### rtl/core/rbcg_geom.sv
// three stage corner offset, rounding and saturating placement pipeline
module rbcg_geom import rbcg_pkg::*; (
  input  logic                              clk_i,
  input  logic [GEO_STG-1:0]                en_i,
  input  logic signed [TRIG_W-1:0]          sin_i,
  input  logic signed [TRIG_W-1:0]          cos_i,
  input  beam_t                             beam_i,
  output logic [NCOORD-1:0][COORD_BITS-1:0] coord_o,
  output logic                              clip_o
);

  logic signed [DIM_BITS:0]  len_s;
  logic signed [DIM_BITS:0]  wid_s;
  logic signed [PROD_W-1:0]  la_prod;
  logic signed [PROD_W-1:0]  lb_prod;
  logic signed [PROD_W-1:0]  wc_d;
  logic signed [PROD_W-1:0]  ws_d;
  logic signed [PROD_W-1:0]  off   [NCOORD];
  logic signed [PROD_W-1:0]  biased[NCOORD];
  logic signed [RND_W-1:0]   rnd_d [NCOORD];
  logic signed [PLACE_W-1:0] sum   [NCOORD];
  logic signed [COORD_BITS-1:0] org;
  logic [NCOORD-1:0][COORD_BITS-1:0] coord_d;
  logic [NCOORD-1:0]         sat;

  logic signed [PROD_W-1:0]     a_q, b_q, wc_q, ws_q;
  logic signed [COORD_BITS-1:0] ox_q [0:1];
  logic signed [COORD_BITS-1:0] oy_q [0:1];
  logic signed [RND_W-1:0]      rnd_q[NCOORD];
  logic [NCOORD-1:0][COORD_BITS-1:0] coord_q;
  logic                         clip_q;

  always_comb begin
    len_s   = signed'({1'b0, beam_i.len});
    wid_s   = signed'({1'b0, beam_i.wid});
    la_prod = len_s * cos_i;
    lb_prod = len_s * sin_i;
    wc_d    = wid_s * cos_i;
    ws_d    = wid_s * sin_i;

    off[0] = ws_q;
    off[1] = -wc_q;
    off[2] = a_q + ws_q;
    off[3] = b_q - wc_q;
    off[4] = a_q - ws_q;
    off[5] = b_q + wc_q;
    off[6] = -ws_q;
    off[7] = wc_q;
    for (int i = 0; i < NCOORD; i++) begin
      biased[i] = off[i] + RND_HALF;
      rnd_d[i]  = RND_W'(biased[i] >>> RND_SH);
    end

    org = '0;
    for (int i = 0; i < NCOORD; i++) begin
      org    = (i % 2 == 0) ? ox_q[1] : oy_q[1];
      sum[i] = PLACE_W'(org) + PLACE_W'(rnd_q[i]);
      if (sum[i] > COORD_MAX) begin
        coord_d[i] = COORD_BITS'(COORD_MAX);
        sat[i]     = 1'b1;
      end else if (sum[i] < COORD_MIN) begin
        coord_d[i] = COORD_BITS'(COORD_MIN);
        sat[i]     = 1'b1;
      end else begin
        coord_d[i] = COORD_BITS'(sum[i]);
        sat[i]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q     <= la_prod <<< 1;
      b_q     <= lb_prod <<< 1;
      wc_q    <= wc_d;
      ws_q    <= ws_d;
      ox_q[0] <= beam_i.ox;
      oy_q[0] <= beam_i.oy;
    end
    if (en_i[1]) begin
      rnd_q   <= rnd_d;
      ox_q[1] <= ox_q[0];
      oy_q[1] <= oy_q[0];
    end
    if (en_i[2]) begin
      coord_q <= coord_d;
      clip_q  <= |sat;
    end
  end

  assign coord_o = coord_q;
  assign clip_o  = clip_q;

endmodule

### rtl/core/rotated_beam_corner_generator_core.sv
// top level of the rotated beam corner generator
// Takes one beam request per clock when not stalled (origin, binary angle, length, width) and returns the
// four corners of the rotated rectangle plus a saturation flag. The path is a nine stage
// pipeline: six stages for the sine and cosine polynomials (one multiply each, two units
// side by side) and three for offset products, rounding and saturating placement.
// Throughput is one request per cycle while the output is not stalled, and back pressure
// on the output stalls only as far back as needed to fill empty stages.
module rotated_beam_corner_generator_core import rbcg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // origin_x, origin_y, angle, beam_length, beam_width
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, corner4_x, corner4_y
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // clipped
  output logic                   m_axis_tuser
);

  beam_t               beam_in;
  logic [ANGLE_BITS-1:0] angle;
  logic [PHASE_W-1:0]  phase;
  logic [1:0]          quad_sin;
  logic [1:0]          quad_cos;
  logic [FRAC_W-1:0]   frac;
  logic [NSTG-1:0]     rdy;
  logic [NSTG-1:0]     vld_q;
  beam_t               beam_q [SIN_STG];
  logic signed [TRIG_W-1:0] sin_val;
  logic signed [TRIG_W-1:0] cos_val;
  logic [NCOORD-1:0][COORD_BITS-1:0] coord;
  logic                clip;

  always_comb begin
    beam_in.ox  = s_axis_tdata[0 +: COORD_BITS];
    beam_in.oy  = s_axis_tdata[OFS_OY +: COORD_BITS];
    angle       = s_axis_tdata[OFS_ANG +: ANGLE_BITS];
    beam_in.len = s_axis_tdata[OFS_LEN +: DIM_BITS];
    beam_in.wid = s_axis_tdata[OFS_WID +: DIM_BITS];
    phase       = {angle, (PHASE_W-ANGLE_BITS)'(0)};
    quad_sin    = phase[PHASE_W-1 -: 2];
    quad_cos    = quad_sin + 2'd1;
    frac        = phase[PHASE_W-3 -: FRAC_W];
  end

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      beam_q[0] <= beam_in;
    end
    for (int k = 1; k < SIN_STG; k++) begin
      if (rdy[k]) begin
        beam_q[k] <= beam_q[k-1];
      end
    end
  end

  rbcg_sin u_sin (
    .clk_i  (clk_i),
    .en_i   (rdy[SIN_STG-1:0]),
    .quad_i (quad_sin),
    .frac_i (frac),
    .sin_o  (sin_val)
  );

  rbcg_sin u_cos (
    .clk_i  (clk_i),
    .en_i   (rdy[SIN_STG-1:0]),
    .quad_i (quad_cos),
    .frac_i (frac),
    .sin_o  (cos_val)
  );

  rbcg_geom u_geom (
    .clk_i   (clk_i),
    .en_i    (rdy[NSTG-1:SIN_STG]),
    .sin_i   (sin_val),
    .cos_i   (cos_val),
    .beam_i  (beam_q[SIN_STG-1]),
    .coord_o (coord),
    .clip_o  (clip)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = OUT_TDATA_W'(coord);
  assign m_axis_tuser  = clip;

endmodule

### rtl/core/rbcg_chk.sv
// port level checker for the rotated beam corner generator, with its bind
module rbcg_chk import rbcg_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  localparam logic [COORD_BITS-1:0] CMAX = COORD_BITS'(COORD_MAX);
  localparam logic [COORD_BITS-1:0] CMIN = COORD_BITS'(COORD_MIN);

  logic at_limit;

  always_comb begin
    at_limit = 1'b0;
    for (int i = 0; i < NCOORD; i++) begin
      if (m_axis_tdata[i*COORD_BITS +: COORD_BITS] == CMAX ||
          m_axis_tdata[i*COORD_BITS +: COORD_BITS] == CMIN) begin
        at_limit = 1'b1;
      end
    end
  end

  // saturation flag only with some coordinate at a range limit
  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> at_limit)
    else $error("clipped set without a saturated corner");

  // an open output lets the whole pipe move
  a_ready_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_drop_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn before it was taken");

endmodule

bind rotated_beam_corner_generator_core rbcg_chk u_chk (.*);
